>>> rtl/rbsi_pkg.sv
// Shared widths, saturation limits and side-band type for the ray/box slab test.
// No dependencies.
package rbsi_pkg;

  localparam int Q_W     = 32;
  localparam int FRAC_W  = 16;
  localparam int NUM_W   = Q_W + 1 + FRAC_W;
  localparam int DIV_LAT = Q_W + 1;
  localparam int AXES    = 3;
  localparam int QUOTS   = 2 * AXES;

  localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic [AXES-1:0][Q_W-1:0] org;
    logic [AXES-1:0][Q_W-1:0] dir;
    logic [QUOTS-1:0]         qneg;
    logic [AXES-1:0]          dzero;
    logic [AXES-1:0]          in_slab;
  } side_t;

endpackage

>>> rtl/rbsi_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage, with overflow flag.
// Depends on rbsi_pkg.
module rbsi_div import rbsi_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num_i,
  input  logic [Q_W-1:0]   den_i,
  output logic [Q_W-1:0]   quot_o,
  output logic             ovf_o
);

  logic [Q_W-1:0] rem_r [0:Q_W];
  logic [Q_W-1:0] low_r [0:Q_W];
  logic [Q_W-1:0] quo_r [0:Q_W];
  logic [Q_W-1:0] den_r [0:Q_W];
  logic           ovf_r [0:Q_W];

  logic [Q_W:0]   trial   [0:Q_W-1];
  logic [Q_W-1:0] rem_nxt [0:Q_W-1];
  logic           qbit    [0:Q_W-1];
  logic [Q_W-1:0] num_hi;

  assign num_hi = {{(2*Q_W-NUM_W){1'b0}}, num_i[NUM_W-1:Q_W]};

  always_comb begin
    for (int k = 0; k < Q_W; k++) begin
      trial[k] = {rem_r[k], low_r[k][Q_W-1]};
      if (trial[k] >= {1'b0, den_r[k]}) begin
        rem_nxt[k] = Q_W'(trial[k] - {1'b0, den_r[k]});
        qbit[k]    = 1'b1;
      end else begin
        rem_nxt[k] = trial[k][Q_W-1:0];
        qbit[k]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_hi;
      low_r[0] <= num_i[Q_W-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den_i;
      ovf_r[0] <= (num_hi >= den_i);
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k+1] <= rem_nxt[k];
        low_r[k+1] <= {low_r[k][Q_W-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][Q_W-2:0], qbit[k]};
        den_r[k+1] <= den_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end
  end

  assign quot_o = quo_r[Q_W];
  assign ovf_o  = ovf_r[Q_W];

endmodule

>>> rtl/ray_box_slab_intersect_top.sv
// Ray versus axis-aligned box slab test, top level with handshake and pipeline.
// Depends on rbsi_pkg and rbsi_div.
//
// Accepts one ray/box item every cycle while the result side takes results;
// each result passes the input stage, the six 33-stage slab dividers (one
// quotient bit per cycle while not stalled), then order, merge, multiply and
// output stages. Backpressure freezes the whole pipeline without loss.
module ray_box_slab_intersect_top import rbsi_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // entry_t, hit_x, hit_y, hit_z
  output logic [127:0] out_tdata,
  // hit
  output logic         out_tuser
);

  logic en;

  logic                     v1_r;
  logic [AXES-1:0][Q_W-1:0] s1_org_r, s1_dir_r, s1_lo_r, s1_hi_r;

  side_t                    side_nxt;
  logic [QUOTS-1:0][NUM_W-1:0] num_nxt;
  logic [AXES-1:0][Q_W-1:0] dmag_nxt;
  logic [Q_W:0]             diff [0:QUOTS-1];
  logic [Q_W:0]             dmag [0:AXES-1];

  side_t                    sd_r [0:DIV_LAT-1];
  logic                     vd_r [0:DIV_LAT-1];
  logic [Q_W-1:0]           quot [0:QUOTS-1];
  logic                     ovf  [0:QUOTS-1];

  logic signed [Q_W-1:0]    tq   [0:QUOTS-1];
  logic [AXES-1:0][Q_W-1:0] tn_nxt, tf_nxt;
  logic [AXES-1:0]          ok_nxt;
  logic                     v3_r;
  logic [AXES-1:0][Q_W-1:0] s3_tn_r, s3_tf_r, s3_org_r, s3_dir_r;
  logic [AXES-1:0]          s3_ok_r;

  logic signed [Q_W-1:0]    tmin_nxt, tmax_nxt;
  logic                     v4_r, s4_hit_r;
  logic [Q_W-1:0]           s4_tmin_r;
  logic [AXES-1:0][Q_W-1:0] s4_org_r, s4_dir_r;

  logic                     v5_r, s5_hit_r;
  logic [Q_W-1:0]           s5_tmin_r;
  logic [AXES-1:0][Q_W-1:0] s5_org_r;
  logic [AXES-1:0][2*Q_W-1:0] s5_prod_r;

  logic [AXES-1:0][Q_W-1:0] pt_nxt;
  logic [Q_W+FRAC_W:0]      psum [0:AXES-1];

  logic                     out_valid_r, out_hit_r;
  logic [127:0]             out_data_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < AXES; i++) begin
        s1_org_r[i] <= in_tdata[Q_W*i +: Q_W];
        s1_dir_r[i] <= in_tdata[Q_W*(AXES+i) +: Q_W];
        s1_lo_r[i]  <= in_tdata[Q_W*(2*AXES+i) +: Q_W];
        s1_hi_r[i]  <= in_tdata[Q_W*(3*AXES+i) +: Q_W];
      end
    end
  end

  always_comb begin
    side_nxt.org = s1_org_r;
    side_nxt.dir = s1_dir_r;
    for (int i = 0; i < AXES; i++) begin
      dmag[i] = s1_dir_r[i][Q_W-1] ? (Q_W+1)'(-$signed({1'b1, s1_dir_r[i]}))
                                   : {1'b0, s1_dir_r[i]};
      dmag_nxt[i] = dmag[i][Q_W-1:0];
      side_nxt.dzero[i]   = (s1_dir_r[i] == '0);
      side_nxt.in_slab[i] = ($signed(s1_org_r[i]) >= $signed(s1_lo_r[i])) &&
                            ($signed(s1_org_r[i]) <= $signed(s1_hi_r[i]));
    end
    for (int d = 0; d < QUOTS; d++) begin
      if (d % 2 == 0) begin
        diff[d] = {s1_lo_r[d/2][Q_W-1], s1_lo_r[d/2]} -
                  {s1_org_r[d/2][Q_W-1], s1_org_r[d/2]};
      end else begin
        diff[d] = {s1_hi_r[d/2][Q_W-1], s1_hi_r[d/2]} -
                  {s1_org_r[d/2][Q_W-1], s1_org_r[d/2]};
      end
      side_nxt.qneg[d] = diff[d][Q_W] ^ s1_dir_r[d/2][Q_W-1];
      num_nxt[d] = {(diff[d][Q_W] ? (Q_W+1)'(-diff[d]) : diff[d]), {FRAC_W{1'b0}}};
    end
  end

  for (genvar g = 0; g < QUOTS; g++) begin : g_div
    rbsi_div u_div (
      .clk    (clk),
      .en     (en),
      .num_i  (num_nxt[g]),
      .den_i  (dmag_nxt[g/2]),
      .quot_o (quot[g]),
      .ovf_o  (ovf[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v1_r;
      for (int k = 1; k < DIV_LAT; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side_nxt;
      for (int k = 1; k < DIV_LAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  always_comb begin
    for (int d = 0; d < QUOTS; d++) begin
      if (sd_r[DIV_LAT-1].qneg[d]) begin
        tq[d] = (ovf[d] || quot[d] > Q_MIN) ? Q_MIN : -$signed(quot[d]);
      end else begin
        tq[d] = (ovf[d] || quot[d][Q_W-1]) ? Q_MAX : $signed(quot[d]);
      end
    end
    for (int i = 0; i < AXES; i++) begin
      ok_nxt[i] = !sd_r[DIV_LAT-1].dzero[i] || sd_r[DIV_LAT-1].in_slab[i];
      if (sd_r[DIV_LAT-1].dzero[i]) begin
        tn_nxt[i] = Q_MIN;
        tf_nxt[i] = Q_MAX;
      end else if (tq[2*i] > tq[2*i+1]) begin
        tn_nxt[i] = tq[2*i+1];
        tf_nxt[i] = tq[2*i];
      end else begin
        tn_nxt[i] = tq[2*i];
        tf_nxt[i] = tq[2*i+1];
      end
    end
  end

  always_comb begin
    tmin_nxt = $signed(s3_tn_r[0]);
    tmax_nxt = $signed(s3_tf_r[0]);
    for (int i = 1; i < AXES; i++) begin
      if ($signed(s3_tn_r[i]) > tmin_nxt) tmin_nxt = $signed(s3_tn_r[i]);
      if ($signed(s3_tf_r[i]) < tmax_nxt) tmax_nxt = $signed(s3_tf_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      psum[i] = {{(FRAC_W+1){s5_org_r[i][Q_W-1]}}, s5_org_r[i]} +
                {s5_prod_r[i][2*Q_W-1], s5_prod_r[i][2*Q_W-1:FRAC_W]};
      if ($signed(psum[i]) > $signed({{(FRAC_W+1){1'b0}}, Q_MAX})) begin
        pt_nxt[i] = Q_MAX;
      end else if ($signed(psum[i]) < $signed({{(FRAC_W+1){1'b1}}, Q_MIN})) begin
        pt_nxt[i] = Q_MIN;
      end else begin
        pt_nxt[i] = psum[i][Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v3_r        <= vd_r[DIV_LAT-1];
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_tn_r  <= tn_nxt;
      s3_tf_r  <= tf_nxt;
      s3_ok_r  <= ok_nxt;
      s3_org_r <= sd_r[DIV_LAT-1].org;
      s3_dir_r <= sd_r[DIV_LAT-1].dir;

      s4_hit_r  <= (&s3_ok_r) && (tmin_nxt <= tmax_nxt);
      s4_tmin_r <= tmin_nxt;
      s4_org_r  <= s3_org_r;
      s4_dir_r  <= s3_dir_r;

      s5_hit_r  <= s4_hit_r;
      s5_tmin_r <= s4_tmin_r;
      s5_org_r  <= s4_org_r;
      for (int i = 0; i < AXES; i++) begin
        s5_prod_r[i] <= $signed(s4_tmin_r) * $signed(s4_dir_r[i]);
      end

      out_hit_r <= s5_hit_r;
      if (s5_hit_r) begin
        out_data_r <= {pt_nxt[2], pt_nxt[1], pt_nxt[0], s5_tmin_r};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_hit_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_data_r == '0)
    else $error("miss result carries nonzero data");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v5_r) && $stable(s5_tmin_r) && $stable(v3_r))
    else $error("pipeline moved during stall");

  a_zero_dir_open: assert property (@(posedge clk) disable iff (!rst_n)
    en && vd_r[DIV_LAT-1] && sd_r[DIV_LAT-1].dzero[0] |=> s3_tn_r[0] == Q_MIN)
    else $error("zero direction slab not unbounded");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v5_r)
    else $error("valid survived reset");

endmodule

>>> tb/ray_box_slab_intersect_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ray_box_slab_intersect_top: directed table plus random
// ray/box transfers, predicted per item and compared in order. Depends on rbsi_pkg.
module ray_box_slab_intersect_top_test;
  import rbsi_pkg::*;

  typedef struct packed {
    logic [31:0] hit_z;
    logic [31:0] hit_y;
    logic [31:0] hit_x;
    logic [31:0] entry_t;
    logic        hit;
  } slab_res_t;

  typedef struct {
    logic [11:0][31:0] f;
    bit                known;
    slab_res_t         res;
  } slab_row_t;

  localparam longint TMAX = 64'sd2147483647;
  localparam longint TMIN = -64'sd2147483648;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [383:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic out_tuser;

  slab_res_t hit_queue[$];
  int errors = 0;
  int cycles = 0;
  bit stim_done = 0;
  bit long_hold = 0;

  ray_box_slab_intersect_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > TMAX) return TMAX;
    if (v < TMIN) return TMIN;
    return v;
  endfunction

  function automatic slab_res_t ray_box_hit(logic [11:0][31:0] f);
    longint o[3], d[3], lo[3], hi[3];
    longint tmin, tmax, a, b, t, p;
    bit ok;
    slab_res_t r;
    tmin = TMIN;
    tmax = TMAX;
    ok = 1;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      o[i] = longint'(signed'(f[i]));
      d[i] = longint'(signed'(f[3+i]));
      lo[i] = longint'(signed'(f[6+i]));
      hi[i] = longint'(signed'(f[9+i]));
    end
    for (int i = 0; i < 3; i++) begin
      if (d[i] == 0) begin
        if (o[i] < lo[i] || o[i] > hi[i]) ok = 0;
        continue;
      end
      a = clamp32(((lo[i] - o[i]) * 65536) / d[i]);
      b = clamp32(((hi[i] - o[i]) * 65536) / d[i]);
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if (a > tmin) tmin = a;
      if (b < tmax) tmax = b;
    end
    if (tmin > tmax) ok = 0;
    if (!ok) return r;
    r.hit = 1'b1;
    r.entry_t = tmin[31:0];
    for (int i = 0; i < 3; i++) begin
      p = (tmin * d[i]) >>> 16;
      t = clamp32(o[i] + p);
      case (i)
        0: r.hit_x = t[31:0];
        1: r.hit_y = t[31:0];
        default: r.hit_z = t[31:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      2: return 32'($signed($urandom_range(0, 64)) - 32) << 16;
      3: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return 32'($signed($urandom_range(0, 40)) - 20) <<< $urandom_range(12, 18);
    endcase
  endfunction

  function automatic logic [11:0][31:0] rand_ray_box();
    logic [11:0][31:0] f;
    logic [31:0] s;
    for (int i = 0; i < 12; i++) f[i] = rand_q();
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 5) == 0) f[3+i] = '0;
      if ($urandom_range(0, 3) != 0 && $signed(f[6+i]) > $signed(f[9+i])) begin
        s = f[6+i];
        f[6+i] = f[9+i];
        f[9+i] = s;
      end
    end
    if ($urandom_range(0, 2) == 0)
      for (int i = 0; i < 3; i++) f[3+i] = f[6+i] + f[9+i] - (f[i] <<< 1);
    return f;
  endfunction

  task automatic send(logic [11:0][31:0] f, bit known, slab_res_t res);
    slab_res_t p;
    @(negedge clk);
    if (!long_hold && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 2))
        @(negedge clk);
    end
    in_tdata <= f;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    p = ray_box_hit(f);
    hit_queue.push_back(known ? res : p);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic walk_table();
    slab_row_t tbl[$];
    slab_row_t row;
    logic [11:0][31:0] f;
    for (int k = 0; k < 20; k++) begin
      row.known = 0;
      row.res = '0;
      for (int i = 0; i < 3; i++) begin
        f[i] = '0;
        f[3+i] = 32'h0001_0000;
        f[6+i] = 32'hffff_0000;
        f[9+i] = 32'h0001_0000;
      end
      case (k)
        0: ;
        1: begin
          f[3] = '0; f[4] = '0; f[5] = '0;
          row.known = 1;
          row.res = '{hit: 1'b1, entry_t: Q_MIN, hit_x: '0, hit_y: '0, hit_z: '0};
        end
        2: begin
          f[3] = '0; f[0] = 32'h0005_0000;
          row.known = 1;
        end
        3: begin
          f[6] = 32'h0001_0000; f[9] = 32'hffff_0000; f[3] = '0;
          row.known = 1;
        end
        4: begin f[6] = 32'h0001_0000; f[9] = 32'hffff_0000; end
        5: begin f[6] = 32'h0010_0000; f[9] = 32'h0020_0000; end
        6: begin f[6] = 32'hffe0_0000; f[9] = 32'hfff0_0000; end
        7: begin f[6] = 32'h0003_0000; f[9] = 32'h0004_0000; f[4] = 32'hffff_0000; end
        8: for (int i = 0; i < 12; i++) f[i] = Q_MAX;
        9: for (int i = 0; i < 12; i++) f[i] = Q_MIN;
        10: begin f[0] = Q_MIN; f[6] = Q_MAX; f[9] = Q_MAX; f[3] = 32'h1; end
        11: begin f[0] = Q_MAX; f[6] = Q_MIN; f[9] = Q_MIN; f[3] = Q_MIN; end
        12: begin f[3] = 32'h1; f[4] = 32'hffff_ffff; f[5] = Q_MAX; end
        13: begin f[6] = 32'h0001_0000; f[9] = 32'h0001_0000; f[0] = 32'h0001_0000; f[3] = '0; end
        14: begin f[6] = 32'h0002_0000; f[9] = 32'h0003_0000;
                  f[7] = 32'h0000_0000; f[10] = 32'h0001_0000; end
        15: begin f[3] = 32'h0000_0003; f[4] = 32'hffff_fffd; f[5] = 32'h7; end
        16: for (int i = 0; i < 12; i++) f[i] = 32'hffff_ffff;
        17: for (int i = 0; i < 12; i++) f[i] = 32'h5555_aaaa ^ {32{i[0]}};
        18: begin f[3] = 32'hfff0_0000; f[6] = 32'h0010_0000; f[9] = 32'h0011_0000; end
        default: f = rand_ray_box();
      endcase
      row.f = f;
      tbl.push_back(row);
    end
    foreach (tbl[k]) send(tbl[k].f, tbl[k].known, tbl[k].res);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    walk_table();
    for (int n = 0; n < 1180; n++) begin
      if (n == 300) begin
        long_hold = 1;
        repeat (60) send(rand_ray_box(), 0, '0);
        long_hold = 0;
      end
      if (n == 700) begin
        go_idle();
        wait (hit_queue.size() == 0);
      end
      send(rand_ray_box(), 0, '0);
    end
    go_idle();
    stim_done = 1;
  end

  initial begin
    bit held;
    held = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold && !held) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (200) @(negedge clk);
      end
      else if ($urandom_range(0, 3) == 0) out_tready <= 1'b0;
      else if ($urandom_range(0, 30) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
      end else out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    slab_res_t want, got;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata, out_tuser};
      if (hit_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %h", got);
      end else begin
        want = hit_queue.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: hit %b/%b t %h/%h x %h/%h y %h/%h z %h/%h",
                     want.hit, got.hit, want.entry_t, got.entry_t, want.hit_x, got.hit_x,
                     want.hit_y, got.hit_y, want.hit_z, got.hit_z);
        end
      end
    end
  end

  initial begin
    wait (stim_done && hit_queue.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && hit_queue.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    wait (cycles >= LIMIT);
    $display("Simulation FAILED");
    $finish;
  end
endmodule

>>> files.f
rtl/rbsi_pkg.sv
rtl/rbsi_div.sv
rtl/ray_box_slab_intersect_top.sv
tb/ray_box_slab_intersect_top_test.sv
